// File: rtl/core/acs_pkg.sv
// acs_pkg: shared types, constants and helpers for the astrometry to
// cartesian pipeline. Used by every module under rtl/core.
// No dependencies.
package acs_pkg;

  // pipeline depths
  localparam int DIV_LAT   = 43;
  localparam int COR_STEPS = 31;
  localparam int COR_LAT   = COR_STEPS + 2;
  localparam int MUL_LAT   = 5;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_NEG = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA    = 8'd1;

  // numerator of the distance division: 1000 * 2^32
  localparam logic [42:0] NUM_SCALE = 43'd4294967296000;

  // cordic start value and arctangent steps in binary angle units
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [29:0] ATAN_STEPS [COR_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1
  };

  // proper motion factor (Q48) and parsec per year factor (Q60)
  localparam logic signed [63:0] AUK_Q48 = 64'sd1334323808385;
  localparam logic signed [63:0] FK_Q60  = 64'sd1179106688220;

  // product magnitude limit
  localparam logic [60:0] CAP60 = 61'h1000_0000_0000_0000;

  typedef logic signed [32:0] trig_t;
  typedef logic signed [43:0] dist_t;
  typedef logic signed [63:0] op_t;
  typedef logic signed [61:0] prod_t;

  // rounding shift of a product
  typedef enum logic [1:0] {
    SH16,
    SH30,
    SH38,
    SH40
  } shift_e;

  typedef struct packed {
    logic        neg;
    logic [31:0] mra;
    logic [31:0] mdec;
    logic [31:0] rv;
    logic [31:0] temp;
    logic [31:0] rad;
    logic [31:0] lum;
  } side_t;

  typedef struct packed {
    trig_t cr;
    trig_t sr;
    trig_t cd;
    trig_t sd;
  } trig4_t;

  typedef struct packed {
    logic        sat;
    logic [47:0] val;
  } clamp_t;

  // clip to the 48 bit output range
  function automatic clamp_t clamp48(input prod_t v);
    clamp_t r;
    r.sat = 1'b0;
    r.val = v[47:0];
    if (v > 62'sh0000_7FFF_FFFF_FFFF) begin
      r.sat = 1'b1;
      r.val = 48'h7FFF_FFFF_FFFF;
    end else if (v < 62'sh3FFF_8000_0000_0000) begin
      r.sat = 1'b1;
      r.val = 48'h8000_0000_0000;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/acs_div.sv
// acs_div: radix-2 restoring divider, one quotient bit per stage,
// computes round(1000 * 2^32 / d). Depends on acs_pkg.
module acs_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] d_i,
  output logic [42:0] q_o
);
  import acs_pkg::*;

  logic [31:0] rem_q [DIV_LAT];
  logic [42:0] n_q   [DIV_LAT];
  logic [31:0] d_q   [DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_st
    logic [31:0] rem_in;
    logic [31:0] d_in;
    logic [42:0] n_in;
    logic [32:0] t;
    logic        ge;

    // first stage adds d/2 for rounding
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign d_in   = d_i;
      assign n_in   = NUM_SCALE + 43'(d_i >> 1);
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign d_in   = d_q[k-1];
      assign n_in   = n_q[k-1];
    end

    // shift in next numerator bit, subtract when it fits
    assign t  = {rem_in, n_in[42]};
    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? 32'(t - {1'b0, d_in}) : t[31:0];
        n_q[k]   <= {n_in[41:0], ge};
        d_q[k]   <= d_in;
      end
    end
  end

  assign q_o = n_q[DIV_LAT-1];

endmodule

// File: rtl/core/acs_cordic.sv
// acs_cordic: pipelined rotation cordic, one step per stage, giving Q30
// cosine and sine of a 32 bit binary angle. Depends on acs_pkg.
module acs_cordic (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [31:0]         angle_i,
  output acs_pkg::trig_t      cos_o,
  output acs_pkg::trig_t      sin_o
);
  import acs_pkg::*;

  logic signed [32:0] x_q [COR_STEPS+1];
  logic signed [32:0] y_q [COR_STEPS+1];
  logic signed [32:0] z_q [COR_STEPS+1];
  logic               f_q [COR_STEPS+1];
  trig_t              cos_q;
  trig_t              sin_q;
  logic signed [32:0] z0;

  assign z0 = $signed({angle_i[31], angle_i});

  // fold the angle into the right half plane by a half turn
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_GAIN;
      y_q[0] <= '0;
      if (z0 > 33'sd1073741824) begin
        z_q[0] <= z0 - 33'sd2147483648;
        f_q[0] <= 1'b1;
      end else if (z0 < -33'sd1073741824) begin
        z_q[0] <= z0 + 33'sd2147483648;
        f_q[0] <= 1'b1;
      end else begin
        z_q[0] <= z0;
        f_q[0] <= 1'b0;
      end
    end
  end

  // rotation steps
  for (genvar i = 0; i < COR_STEPS; i++) begin : g_it
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] at;

    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    assign at = $signed({3'b000, ATAN_STEPS[i]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + at;
        end
        f_q[i+1] <= f_q[i];
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= f_q[COR_STEPS] ? -x_q[COR_STEPS] : x_q[COR_STEPS];
      sin_q <= f_q[COR_STEPS] ? -y_q[COR_STEPS] : y_q[COR_STEPS];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// File: rtl/core/acs_mul.sv
// acs_mul: five stage signed multiplier built from 32x32 partial products,
// rounds half away from zero and limits the magnitude to 2^60.
// Depends on acs_pkg.
module acs_mul (
  input  logic            clk_i,
  input  logic            en_i,
  input  acs_pkg::op_t    a_i,
  input  acs_pkg::op_t    b_i,
  input  acs_pkg::shift_e sh_i,
  output acs_pkg::prod_t  p_o
);
  import acs_pkg::*;

  logic [63:0]  a_q, b_q;
  logic [63:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [127:0] prod_q;
  logic [60:0]  mag_q;
  prod_t        p_q;
  logic         neg1_q, neg2_q, neg3_q, neg4_q;
  shift_e       sh1_q, sh2_q, sh3_q;
  logic [127:0] rs;

  // magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      b_q    <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg1_q <= a_i[63] ^ b_i[63];
      sh1_q  <= sh_i;
    end
  end

  // partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= a_q[31:0] * b_q[31:0];
      pp01_q <= a_q[31:0] * b_q[63:32];
      pp10_q <= a_q[63:32] * b_q[31:0];
      pp11_q <= a_q[63:32] * b_q[63:32];
      neg2_q <= neg1_q;
      sh2_q  <= sh1_q;
    end
  end

  // full product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {64'd0, pp00_q} + {32'd0, pp01_q, 32'd0}
              + {32'd0, pp10_q, 32'd0} + {pp11_q, 64'd0};
      neg3_q <= neg2_q;
      sh3_q  <= sh2_q;
    end
  end

  // round and limit
  always_comb begin
    unique case (sh3_q)
      SH16: rs = (prod_q + (128'd1 << 15)) >> 16;
      SH30: rs = (prod_q + (128'd1 << 29)) >> 30;
      SH38: rs = (prod_q + (128'd1 << 37)) >> 38;
      SH40: rs = (prod_q + (128'd1 << 39)) >> 40;
      default: rs = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= (rs > 128'(CAP60)) ? CAP60 : rs[60:0];
      neg4_q <= neg3_q;
    end
  end

  // apply sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg4_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    end
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/astrometry_to_cartesian.sv
// astrometry_to_cartesian: top level, star catalog entry to cartesian
// position and velocity. Depends on acs_pkg, acs_div, acs_cordic, acs_mul.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one star per transfer.
//   Output channel (out_valid_o / out_stall_i) gives one result per kept
//   star; stars with zero parallax, or negative parallax while
//   keep_negative is 0, give no result.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes register
//   cfg_index_i with bit 0 of cfg_data_i: 0 keep_negative, 1 extra_enable.
//   It is always ready; other indexes are ignored.
//   A result passes through one input stage, 43 divider stages, one sign
//   stage, four chained multiplier levels of 5 stages, a sum stage and the
//   output register.
//   Throughput: one star per cycle, limited by nothing but the output.
//   The cordics (33 stages) run beside the divider.
//   Reset clears both registers to 0 and empties the pipeline.
//   While a result waits under out_stall_i, the whole pipeline holds and
//   in_stall_o is raised; nothing is lost or repeated.
module astrometry_to_cartesian (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] right_ascension_i,
  input  logic signed [31:0] declination_i,
  input  logic signed [31:0] parallax_i,
  input  logic signed [31:0] motion_ra_i,
  input  logic signed [31:0] motion_dec_i,
  input  logic signed [31:0] line_of_sight_speed_i,
  input  logic [31:0] temperature_word_i,
  input  logic [31:0] radius_word_i,
  input  logic [31:0] luminosity_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic signed [47:0] pos_z_o,
  output logic signed [47:0] vel_x_o,
  output logic signed [47:0] vel_y_o,
  output logic signed [47:0] vel_z_o,
  output logic [31:0] temperature_out_o,
  output logic [31:0] radius_out_o,
  output logic [31:0] luminosity_out_o,
  output logic        saturated_o
);
  import acs_pkg::*;

  localparam int VLAT    = 1 + DIV_LAT + 1 + 4 * MUL_LAT + 2;
  localparam int TRIG_DL = DIV_LAT - COR_LAT;
  localparam int POSXY_DL = 2 * MUL_LAT + 1;
  localparam int POSZ_DL  = 3 * MUL_LAT + 1;
  localparam int WORD_DL  = 4 * MUL_LAT + 1;

  logic        en;
  logic        keep_neg_q, extra_q;
  logic        v_q [VLAT];
  logic        keep;

  logic [31:0] ra_q, dec_q;
  logic [31:0] par_q;
  side_t       side_q;
  logic [31:0] dmag;
  logic [42:0] quo;
  trig_t       cr, sr, cd, sd;

  side_t       side_dl_q [DIV_LAT];
  trig4_t      trig_dl_q [TRIG_DL];

  dist_t       dist_q;
  trig4_t      trig_t0_q;
  side_t       side_t0_q;

  dist_t       dist_dl_q [MUL_LAT];
  trig4_t      trig_l3_q [2 * MUL_LAT];
  logic [31:0] rv_l3_q   [2 * MUL_LAT];
  prod_t       cdcr_dl_q [MUL_LAT];
  prod_t       cdsr_dl_q [MUL_LAT];
  prod_t       sdcr_dl_q [MUL_LAT];
  prod_t       sdsr_dl_q [MUL_LAT];
  prod_t       px_dl_q   [POSXY_DL];
  prod_t       py_dl_q   [POSXY_DL];
  prod_t       pz_dl_q   [POSZ_DL];
  logic [95:0] word_dl_q [WORD_DL];

  prod_t cdcr, cdsr, sdcr, sdsr, pz, k1a, k1d;
  prod_t px, py, kra, kdec;
  prod_t m_srk, m_sdcrk, m_cdcrv, m_crk, m_sdsrk, m_cdsrv, m_cdk, m_sdrv;
  prod_t vx, vy, vz;
  op_t   rv_op;
  op_t   sx_q, sy_q, sz_q;

  clamp_t cx, cy, cz, wx, wy, wz;

  // whole pipeline holds while a result waits
  assign en          = !(v_q[VLAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = v_q[VLAT-1];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_neg_q <= 1'b0;
      extra_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_KEEP_NEG) begin
        keep_neg_q <= cfg_data_i[0];
      end else if (cfg_index_i == REG_EXTRA) begin
        extra_q <= cfg_data_i[0];
      end
    end
  end

  // drop zero parallax and unwanted negative parallax at the door
  assign keep = (parallax_i != '0) && (!parallax_i[31] || keep_neg_q);

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VLAT; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i && keep;
      for (int k = 1; k < VLAT; k++) v_q[k] <= v_q[k-1];
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q         <= right_ascension_i;
      dec_q        <= declination_i;
      par_q        <= parallax_i;
      side_q.neg   <= parallax_i[31];
      side_q.mra   <= motion_ra_i;
      side_q.mdec  <= motion_dec_i;
      side_q.rv    <= line_of_sight_speed_i;
      side_q.temp  <= temperature_word_i;
      side_q.rad   <= radius_word_i;
      side_q.lum   <= luminosity_word_i;
    end
  end

  assign dmag = par_q[31] ? 32'(-par_q) : par_q;

  acs_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dmag),
    .q_o   (quo)
  );

  acs_cordic u_cor_ra (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (ra_q),
    .cos_o   (cr),
    .sin_o   (sr)
  );

  acs_cordic u_cor_dec (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (dec_q),
    .cos_o   (cd),
    .sin_o   (sd)
  );

  // align side data and angles with the quotient
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dl_q[0] <= side_q;
      for (int k = 1; k < DIV_LAT; k++) side_dl_q[k] <= side_dl_q[k-1];
      trig_dl_q[0] <= '{cr: cr, sr: sr, cd: cd, sd: sd};
      for (int k = 1; k < TRIG_DL; k++) trig_dl_q[k] <= trig_dl_q[k-1];
    end
  end

  // signed distance
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q    <= side_dl_q[DIV_LAT-1].neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      trig_t0_q <= trig_dl_q[TRIG_DL-1];
      side_t0_q <= side_dl_q[DIV_LAT-1];
    end
  end

  // level 1 products
  acs_mul u_cdcr (.clk_i(clk_i), .en_i(en), .a_i(64'(trig_t0_q.cd)),
                  .b_i(64'(trig_t0_q.cr)), .sh_i(SH30), .p_o(cdcr));
  acs_mul u_cdsr (.clk_i(clk_i), .en_i(en), .a_i(64'(trig_t0_q.cd)),
                  .b_i(64'(trig_t0_q.sr)), .sh_i(SH30), .p_o(cdsr));
  acs_mul u_sdcr (.clk_i(clk_i), .en_i(en), .a_i(64'(trig_t0_q.sd)),
                  .b_i(64'(trig_t0_q.cr)), .sh_i(SH30), .p_o(sdcr));
  acs_mul u_sdsr (.clk_i(clk_i), .en_i(en), .a_i(64'(trig_t0_q.sd)),
                  .b_i(64'(trig_t0_q.sr)), .sh_i(SH30), .p_o(sdsr));
  acs_mul u_pz   (.clk_i(clk_i), .en_i(en), .a_i(64'(dist_q)),
                  .b_i(64'(trig_t0_q.sd)), .sh_i(SH30), .p_o(pz));
  acs_mul u_k1a  (.clk_i(clk_i), .en_i(en), .a_i(64'(dist_q)),
                  .b_i(64'($signed(side_t0_q.mra))), .sh_i(SH16), .p_o(k1a));
  acs_mul u_k1d  (.clk_i(clk_i), .en_i(en), .a_i(64'(dist_q)),
                  .b_i(64'($signed(side_t0_q.mdec))), .sh_i(SH16), .p_o(k1d));

  // operand delays between levels
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_dl_q[0] <= dist_q;
      cdcr_dl_q[0] <= cdcr;
      cdsr_dl_q[0] <= cdsr;
      sdcr_dl_q[0] <= sdcr;
      sdsr_dl_q[0] <= sdsr;
      for (int k = 1; k < MUL_LAT; k++) begin
        dist_dl_q[k] <= dist_dl_q[k-1];
        cdcr_dl_q[k] <= cdcr_dl_q[k-1];
        cdsr_dl_q[k] <= cdsr_dl_q[k-1];
        sdcr_dl_q[k] <= sdcr_dl_q[k-1];
        sdsr_dl_q[k] <= sdsr_dl_q[k-1];
      end
      trig_l3_q[0] <= trig_t0_q;
      rv_l3_q[0]   <= side_t0_q.rv;
      for (int k = 1; k < 2 * MUL_LAT; k++) begin
        trig_l3_q[k] <= trig_l3_q[k-1];
        rv_l3_q[k]   <= rv_l3_q[k-1];
      end
      px_dl_q[0] <= px;
      py_dl_q[0] <= py;
      for (int k = 1; k < POSXY_DL; k++) begin
        px_dl_q[k] <= px_dl_q[k-1];
        py_dl_q[k] <= py_dl_q[k-1];
      end
      pz_dl_q[0] <= pz;
      for (int k = 1; k < POSZ_DL; k++) pz_dl_q[k] <= pz_dl_q[k-1];
      word_dl_q[0] <= {side_t0_q.temp, side_t0_q.rad, side_t0_q.lum};
      for (int k = 1; k < WORD_DL; k++) word_dl_q[k] <= word_dl_q[k-1];
    end
  end

  // level 2 products: x and y position, proper motions in km/s
  acs_mul u_px   (.clk_i(clk_i), .en_i(en), .a_i(64'(dist_dl_q[MUL_LAT-1])),
                  .b_i(64'(cdcr)), .sh_i(SH30), .p_o(px));
  acs_mul u_py   (.clk_i(clk_i), .en_i(en), .a_i(64'(dist_dl_q[MUL_LAT-1])),
                  .b_i(64'(cdsr)), .sh_i(SH30), .p_o(py));
  acs_mul u_kra  (.clk_i(clk_i), .en_i(en), .a_i(64'(k1a)),
                  .b_i(AUK_Q48), .sh_i(SH38), .p_o(kra));
  acs_mul u_kdec (.clk_i(clk_i), .en_i(en), .a_i(64'(k1d)),
                  .b_i(AUK_Q48), .sh_i(SH38), .p_o(kdec));

  // radial velocity in Q20
  assign rv_op = $signed({{22{rv_l3_q[2*MUL_LAT-1][31]}}, rv_l3_q[2*MUL_LAT-1], 10'b0});

  // level 3 products: basis vector terms
  acs_mul u_srk   (.clk_i(clk_i), .en_i(en), .a_i(64'(trig_l3_q[2*MUL_LAT-1].sr)),
                   .b_i(64'(kra)), .sh_i(SH30), .p_o(m_srk));
  acs_mul u_sdcrk (.clk_i(clk_i), .en_i(en), .a_i(64'(sdcr_dl_q[MUL_LAT-1])),
                   .b_i(64'(kdec)), .sh_i(SH30), .p_o(m_sdcrk));
  acs_mul u_cdcrv (.clk_i(clk_i), .en_i(en), .a_i(64'(cdcr_dl_q[MUL_LAT-1])),
                   .b_i(rv_op), .sh_i(SH30), .p_o(m_cdcrv));
  acs_mul u_crk   (.clk_i(clk_i), .en_i(en), .a_i(64'(trig_l3_q[2*MUL_LAT-1].cr)),
                   .b_i(64'(kra)), .sh_i(SH30), .p_o(m_crk));
  acs_mul u_sdsrk (.clk_i(clk_i), .en_i(en), .a_i(64'(sdsr_dl_q[MUL_LAT-1])),
                   .b_i(64'(kdec)), .sh_i(SH30), .p_o(m_sdsrk));
  acs_mul u_cdsrv (.clk_i(clk_i), .en_i(en), .a_i(64'(cdsr_dl_q[MUL_LAT-1])),
                   .b_i(rv_op), .sh_i(SH30), .p_o(m_cdsrv));
  acs_mul u_cdk   (.clk_i(clk_i), .en_i(en), .a_i(64'(trig_l3_q[2*MUL_LAT-1].cd)),
                   .b_i(64'(kdec)), .sh_i(SH30), .p_o(m_cdk));
  acs_mul u_sdrv  (.clk_i(clk_i), .en_i(en), .a_i(64'(trig_l3_q[2*MUL_LAT-1].sd)),
                   .b_i(rv_op), .sh_i(SH30), .p_o(m_sdrv));

  // velocity sums in km/s
  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= 64'(m_cdcrv) - 64'(m_srk) - 64'(m_sdcrk);
      sy_q <= 64'(m_crk) - 64'(m_sdsrk) + 64'(m_cdsrv);
      sz_q <= 64'(m_cdk) + 64'(m_sdrv);
    end
  end

  // level 4 products: scale to parsec per year
  acs_mul u_vx (.clk_i(clk_i), .en_i(en), .a_i(sx_q), .b_i(FK_Q60),
                .sh_i(SH40), .p_o(vx));
  acs_mul u_vy (.clk_i(clk_i), .en_i(en), .a_i(sy_q), .b_i(FK_Q60),
                .sh_i(SH40), .p_o(vy));
  acs_mul u_vz (.clk_i(clk_i), .en_i(en), .a_i(sz_q), .b_i(FK_Q60),
                .sh_i(SH40), .p_o(vz));

  assign cx = clamp48(px_dl_q[POSXY_DL-1]);
  assign cy = clamp48(py_dl_q[POSXY_DL-1]);
  assign cz = clamp48(pz_dl_q[POSZ_DL-1]);
  assign wx = clamp48(vx);
  assign wy = clamp48(vy);
  assign wz = clamp48(vz);

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_o <= cx.val;
      pos_y_o <= cy.val;
      pos_z_o <= cz.val;
      if (extra_q) begin
        vel_x_o           <= wx.val;
        vel_y_o           <= wy.val;
        vel_z_o           <= wz.val;
        temperature_out_o <= word_dl_q[WORD_DL-1][95:64];
        radius_out_o      <= word_dl_q[WORD_DL-1][63:32];
        luminosity_out_o  <= word_dl_q[WORD_DL-1][31:0];
        saturated_o       <= cx.sat | cy.sat | cz.sat | wx.sat | wy.sat | wz.sat;
      end else begin
        vel_x_o           <= '0;
        vel_y_o           <= '0;
        vel_z_o           <= '0;
        temperature_out_o <= '0;
        radius_out_o      <= '0;
        luminosity_out_o  <= '0;
        saturated_o       <= cx.sat | cy.sat | cz.sat;
      end
    end
  end

endmodule

// File: test/tb_astrometry_to_cartesian.sv
// tb_astrometry_to_cartesian: self-checking testbench for the astrometry to
// cartesian pipeline. Depends on acs_pkg and astrometry_to_cartesian.
// Directed and random stars, random gaps and stalls; checked by a local predictor.
module tb_astrometry_to_cartesian;
  import acs_pkg::*;

  typedef struct {
    logic [31:0] ra;
    logic [31:0] dec;
    logic [31:0] plx;
    logic [31:0] mra;
    logic [31:0] mdec;
    logic [31:0] rv;
    logic [31:0] temp;
    logic [31:0] rad;
    logic [31:0] lum;
  } star_t;

  typedef struct {
    logic [47:0] px, py, pz, vx, vy, vz;
    logic [31:0] temp, rad, lum;
    logic        sat;
  } place_t;

  localparam longint CAP = 64'h1000_0000_0000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [47:0] pos_x_o, pos_y_o, pos_z_o, vel_x_o, vel_y_o, vel_z_o;
  logic [31:0] temperature_out_o, radius_out_o, luminosity_out_o;
  logic saturated_o;

  star_t  cur_star = '{default: '0};
  star_t  pending_stars[$];
  place_t expected_places[$];
  bit     keep_neg_m = 1'b0;
  bit     extra_m = 1'b0;
  bit     no_gaps = 1'b0;
  bit     failed = 1'b0;
  int     send_gap = 0;
  int     stall_left = 0;

  astrometry_to_cartesian uut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .right_ascension_i(cur_star.ra), .declination_i(cur_star.dec),
    .parallax_i(cur_star.plx), .motion_ra_i(cur_star.mra),
    .motion_dec_i(cur_star.mdec), .line_of_sight_speed_i(cur_star.rv),
    .temperature_word_i(cur_star.temp), .radius_word_i(cur_star.rad),
    .luminosity_word_i(cur_star.lum),
    .out_valid_o, .out_stall_i, .pos_x_o, .pos_y_o, .pos_z_o,
    .vel_x_o, .vel_y_o, .vel_z_o, .temperature_out_o, .radius_out_o,
    .luminosity_out_o, .saturated_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // rounded product a*b/2^s, half away from zero, magnitude capped
  function automatic longint round_mul(longint a, longint b, int s);
    logic [63:0]  ua, ub;
    logic [127:0] p;
    bit           neg;
    ua = a[63] ? ~a + 64'd1 : a;
    ub = b[63] ? ~b + 64'd1 : b;
    neg = a[63] ^ b[63];
    p = {64'd0, ua} * {64'd0, ub};
    p = (p + (128'd1 << (s - 1))) >> s;
    if (p > 128'(CAP)) p = 128'(CAP);
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // q30 cosine and sine of a binary angle
  function automatic void trig_q30(input logic [31:0] ang, output longint c,
                                   output longint s);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(signed'(ang));
    x = longint'(CORDIC_GAIN);
    y = 0;
    flip = 1'b0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1'b1;
    end
    for (int i = 0; i < COR_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_STEPS[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_STEPS[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [47:0] clip48(longint v, ref bit sat);
    if (v > 64'sh7FFF_FFFF_FFFF) begin
      sat = 1'b1; return 48'h7FFF_FFFF_FFFF;
    end
    if (v < -64'sh8000_0000_0000) begin
      sat = 1'b1; return 48'h8000_0000_0000;
    end
    return v[47:0];
  endfunction

  // expected cartesian place of one star; returns 0 when the star is dropped
  function automatic bit place_star(star_t st, output place_t r);
    longint par, dpc, cr, sr, cd, sd, cdcr, cdsr, sdcr, sdsr;
    longint kra, kdec, rvq, sx, sy, sz;
    logic [63:0] d, q;
    bit sat;
    r = '{default: '0};
    sat = 1'b0;
    par = longint'(signed'(st.plx));
    if (par == 0 || (par < 0 && !keep_neg_m)) return 1'b0;
    d = par < 0 ? -par : par;
    q = (64'd4294967296000 + d / 2) / d;
    dpc = par < 0 ? -longint'(q) : longint'(q);
    trig_q30(st.ra, cr, sr);
    trig_q30(st.dec, cd, sd);
    cdcr = round_mul(cd, cr, 30);
    cdsr = round_mul(cd, sr, 30);
    sdcr = round_mul(sd, cr, 30);
    sdsr = round_mul(sd, sr, 30);
    r.px = clip48(round_mul(dpc, cdcr, 30), sat);
    r.py = clip48(round_mul(dpc, cdsr, 30), sat);
    r.pz = clip48(round_mul(dpc, sd, 30), sat);
    if (extra_m) begin
      kra = round_mul(round_mul(dpc, longint'(signed'(st.mra)), 16), AUK_Q48, 38);
      kdec = round_mul(round_mul(dpc, longint'(signed'(st.mdec)), 16), AUK_Q48, 38);
      rvq = longint'(signed'(st.rv)) * 1024;
      sx = -round_mul(sr, kra, 30) - round_mul(sdcr, kdec, 30) + round_mul(cdcr, rvq, 30);
      sy = round_mul(cr, kra, 30) - round_mul(sdsr, kdec, 30) + round_mul(cdsr, rvq, 30);
      sz = round_mul(cd, kdec, 30) + round_mul(sd, rvq, 30);
      r.vx = clip48(round_mul(sx, FK_Q60, 40), sat);
      r.vy = clip48(round_mul(sy, FK_Q60, 40), sat);
      r.vz = clip48(round_mul(sz, FK_Q60, 40), sat);
      r.temp = st.temp;
      r.rad = st.rad;
      r.lum = st.lum;
    end
    r.sat = sat;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    if (no_gaps || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: one star per transfer
  always @(posedge clk_i) begin
    place_t p;
    if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i && place_star(cur_star, p)) expected_places = {expected_places, p};
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_stars.size() > 0) begin
        cur_star <= pending_stars.pop_front();
        in_valid_i <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // monitor: random stalls, compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    place_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_places.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none actual x %h",
                 $time, pos_x_o);
        failed = 1'b1;
      end else begin
        e = expected_places.pop_front();
        check_field("pos_x", e.px, pos_x_o);
        check_field("pos_y", e.py, pos_y_o);
        check_field("pos_z", e.pz, pos_z_o);
        check_field("vel_x", e.vx, vel_x_o);
        check_field("vel_y", e.vy, vel_y_o);
        check_field("vel_z", e.vz, vel_z_o);
        check_field("temperature_out", 48'(e.temp), 48'(temperature_out_o));
        check_field("radius_out", 48'(e.rad), 48'(radius_out_o));
        check_field("luminosity_out", 48'(e.lum), 48'(luminosity_out_o));
        check_field("saturated", 48'(e.sat), 48'(saturated_o));
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_KEEP_NEG) keep_neg_m = val[0];
    else if (idx == REG_EXTRA) extra_m = val[0];
    cfg_valid_i <= 1'b0;
  endtask

  // wait until the pipeline has drained completely
  task automatic drain();
    while (pending_stars.size() > 0 || in_valid_i || expected_places.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic star_t star_of(logic [31:0] ra, logic [31:0] dec,
                                    logic [31:0] plx, logic [31:0] m);
    star_t st;
    st = '{ra, dec, plx, m, ~m, m ^ 32'h5555_5555,
           $urandom, $urandom, $urandom};
    return st;
  endfunction

  function automatic logic [31:0] rand_signed(int bits);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, (32'd1 << bits) - 1) - (32'd1 << (bits - 1));
  endfunction

  function automatic star_t random_star();
    star_t st;
    int pick;
    st.ra = $urandom;
    st.dec = ($urandom_range(0, 9) == 0) ? $urandom
           : $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    pick = $urandom_range(0, 19);
    if (pick == 0) st.plx = '0;
    else if (pick < 3) st.plx = $urandom;
    else begin
      st.plx = $urandom_range(32'd1 << 8, 32'd1 << 24);
      if ($urandom_range(0, 3) == 0) st.plx = -st.plx;
    end
    st.mra = rand_signed(22);
    st.mdec = rand_signed(22);
    st.rv = rand_signed(20);
    st.temp = $urandom;
    st.rad = $urandom;
    st.lum = $urandom;
    return st;
  endfunction

  // append one star to the pending queue
  task automatic add_star(star_t st);
    pending_stars = {pending_stars, st};
  endtask

  task automatic load_directed();
    add_star(star_of(32'h0, 32'h0, 32'h0001_0000, 32'h0));
    add_star(star_of(32'hFFFF_FFFF, 32'h4000_0000, 32'h0000_0001, 32'h7FFF_FFFF));
    add_star(star_of(32'h4000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    add_star(star_of(32'h8000_0000, 32'h2000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
    add_star(star_of(32'hC000_0000, 32'hE000_0000, 32'hFFFF_FFFF, 32'h0000_0400));
    add_star(star_of(32'h1234_5678, 32'h0, 32'h0, 32'h1));
    add_star(star_of(32'h2000_0000, 32'h8000_0000, 32'h000A_0000, 32'h0010_0000));
    add_star(star_of(32'h6000_0000, 32'h7FFF_FFFF, 32'hFFF6_0000, 32'hFFF0_0000));
    add_star(star_of(32'hA000_0000, 32'h4000_0001, 32'h0000_8000, 32'h0800_0000));
    add_star(star_of(32'hE000_0000, 32'hBFFF_FFFF, 32'h0064_0000, 32'h0000_0000));
    add_star(star_of(32'h5555_5555, 32'h1555_5555, 32'h0000_0010, 32'h7FFF_FFFF));
    add_star(star_of(32'hAAAA_AAAA, 32'hEAAA_AAAA, 32'hFFFF_FFF0, 32'h8000_0000));
  endtask

  task automatic load_random(int n);
    repeat (n) add_star(random_star());
  endtask

  // stimulus and phases
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // reset settings: negatives dropped, extras off
    load_directed();
    drain();
    write_reg(REG_KEEP_NEG, 32'h1);
    write_reg(REG_EXTRA, 32'hFFFF_FFFF);
    write_reg(8'd5, 32'h0);
    load_directed();
    no_gaps = 1'b1;
    load_random(60);
    drain();
    no_gaps = 1'b0;
    load_random(60);
    drain();
    write_reg(REG_KEEP_NEG, 32'hFFFF_FFFE);
    write_reg(REG_EXTRA, 32'h1);
    load_random(100);
    drain();
    write_reg(REG_KEEP_NEG, 32'h1);
    write_reg(REG_EXTRA, 32'h0);
    load_random(90);
    drain();
    write_reg(8'hFF, 32'hFFFF_FFFF);
    write_reg(REG_EXTRA, 32'h1);
    load_random(90);
    drain();
    repeat (20) @(posedge clk_i);
    if (!failed) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
